[src/cqi_pucch_slot_allocator_top_assert.svh]
// ---------------------------------------------------------------------------
// CQI PUCCH slot allocator assertion macros
// Clocked, reset-gated property wrappers used by the assertion checker.
// ---------------------------------------------------------------------------
`ifndef CQI_PUCCH_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define CQI_PUCCH_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define CQIPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CQIPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/cqips_pkg.sv]
// ---------------------------------------------------------------------------
// CQI PUCCH slot allocator package
// Transaction types, register map, status codes and small lookup functions.
// ---------------------------------------------------------------------------
`default_nettype none

package cqips_pkg;

	// table geometry defaults
	localparam int unsigned MAX_PRB_DEF = 16;
	localparam int unsigned MAX_SF_DEF  = 8;

	// configuration port geometry
	localparam int unsigned PADDR_W = 6;
	localparam int unsigned PDATA_W = 64;
	localparam int unsigned CNT_W   = 6;

	// register indexes (byte address = 8 * index)
	localparam logic [2:0] REG_PRB_COUNT   = 3'd0;
	localparam logic [2:0] REG_SF_COUNT    = 3'd1;
	localparam logic [2:0] REG_NORMAL_CP   = 3'd2;
	localparam logic [2:0] REG_PUCCH_SHIFT = 3'd3;
	localparam logic [2:0] REG_AN_CS       = 3'd4;
	localparam logic [2:0] REG_PERIOD      = 3'd5;
	localparam logic [2:0] REG_SF_OFFSETS  = 3'd6;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_BAD_PERIOD = 3'd2;
	localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
	localparam logic [2:0] ST_EMPTY      = 3'd4;

	// item action codes
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// report periods with special PMI handling and their PMI bases
	localparam logic [7:0] PER_2   = 8'd2;
	localparam logic [7:0] PER_32  = 8'd32;
	localparam logic [7:0] PER_64  = 8'd64;
	localparam logic [7:0] PER_128 = 8'd128;
	localparam logic [9:0] PMI_BASE_32  = 10'd318;
	localparam logic [9:0] PMI_BASE_64  = 10'd350;
	localparam logic [9:0] PMI_BASE_128 = 10'd414;
	localparam logic [9:0] PMI_ADJ      = 10'd3;

	typedef struct packed {
		logic       action;
		logic [3:0] release_prb;
		logic [2:0] release_sf;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  pmi_index;
		logic [10:0] pucch_index;
		logic [3:0]  prb_index;
		logic [2:0]  subframe_index;
	} out_item_t;

	typedef struct packed {
		logic [4:0]  prb_count;
		logic [3:0]  subframe_count;
		logic        normal_cp;
		logic [1:0]  pucch_shift;
		logic [2:0]  an_cyclic_shifts;
		logic [7:0]  report_period;
		logic [63:0] subframe_offsets;
	} cfg_t;

	// users per PRB: 12 * c / shift, shift 0 taken as 1
	function automatic logic [CNT_W-1:0] users_per_prb(input logic ncp, input logic [1:0] sh);
		logic [CNT_W-1:0] mu;
		unique case (sh)
			2'd2:    mu = ncp ? 6'd18 : 6'd12;
			2'd3:    mu = ncp ? 6'd12 : 6'd8;
			default: mu = ncp ? 6'd36 : 6'd24;
		endcase
		return mu;
	endfunction

	function automatic logic period_valid(input logic [7:0] p);
		return (p == 8'd2) || (p == 8'd5) || (p == 8'd10) || (p == 8'd20) ||
			(p == 8'd40) || (p == 8'd80) || (p == 8'd160) || (p == PER_32) ||
			(p == PER_64) || (p == PER_128);
	endfunction

endpackage

`default_nettype wire

[src/cqips_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cqips_ram #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/cqips_regs.sv]
// ---------------------------------------------------------------------------
// CQI PUCCH slot allocator configuration registers
// APB-style register file, zero wait states, 64-bit data at 8-byte stride.
// ---------------------------------------------------------------------------
`default_nettype none

module cqips_regs
	import cqips_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.prb_count        <= 5'd1;
			cfg.subframe_count   <= 4'd1;
			cfg.normal_cp        <= 1'b1;
			cfg.pucch_shift      <= 2'd1;
			cfg.an_cyclic_shifts <= 3'd0;
			cfg.report_period    <= 8'd40;
			cfg.subframe_offsets <= 64'd0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PRB_COUNT:   cfg.prb_count        <= pwdata[4:0];
				REG_SF_COUNT:    cfg.subframe_count   <= pwdata[3:0];
				REG_NORMAL_CP:   cfg.normal_cp        <= pwdata[0];
				REG_PUCCH_SHIFT: cfg.pucch_shift      <= pwdata[1:0];
				REG_AN_CS:       cfg.an_cyclic_shifts <= pwdata[2:0];
				REG_PERIOD:      cfg.report_period    <= pwdata[7:0];
				REG_SF_OFFSETS:  cfg.subframe_offsets <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_PRB_COUNT:   prdata = PDATA_W'(cfg.prb_count);
			REG_SF_COUNT:    prdata = PDATA_W'(cfg.subframe_count);
			REG_NORMAL_CP:   prdata = PDATA_W'(cfg.normal_cp);
			REG_PUCCH_SHIFT: prdata = PDATA_W'(cfg.pucch_shift);
			REG_AN_CS:       prdata = PDATA_W'(cfg.an_cyclic_shifts);
			REG_PERIOD:      prdata = PDATA_W'(cfg.report_period);
			REG_SF_OFFSETS:  prdata = cfg.subframe_offsets;
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[src/cqi_pucch_slot_allocator_top.sv]
// ---------------------------------------------------------------------------
// CQI PUCCH slot allocator
// Assigns CQI/PUCCH slots from a table of per-slot user counts.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_item) carries allocate or release
//   requests; output channel (out_valid/out_stall/out_item) returns exactly
//   one result per request. Registers are to be written over the APB-style port
//   only while the block is idle; the block itself does not enforce this.
//   Allocate: one table read per slot through the count RAM, pipelined
//   against a single compare unit, then the drain, fetch, calc and commit
//   states load the result; zero rows or columns skip the scan.
//   Release: a read state, then a write state that decrements and loads the result.
//   One request is in flight at a time; in_stall is high from acceptance
//   until the result is loaded into the output register, so a new request
//   is not taken before the last one is through.
//   If the receiver stalls, the finished result holds in the output register
//   and a following result waits in the sequencer until the register frees.
//   Reset clears all user counts (per-slot valid bits) and loads the
//   register defaults; the block is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module cqi_pucch_slot_allocator_top
	import cqips_pkg::*;
#(
	parameter int unsigned MAX_PRB = MAX_PRB_DEF,
	parameter int unsigned MAX_SF  = MAX_SF_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_item_t               out_item
);

	localparam int unsigned DEPTH  = MAX_PRB * MAX_SF;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned PRB_W  = (MAX_PRB > 1) ? $clog2(MAX_PRB) : 1;
	localparam int unsigned SF_W   = (MAX_SF > 1) ? $clog2(MAX_SF) : 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DRAIN  = 8'b0000_0100,
		S_FETCH  = 8'b0000_1000,
		S_CALC   = 8'b0001_0000,
		S_COMMIT = 8'b0010_0000,
		S_REL_RD = 8'b0100_0000,
		S_REL_WR = 8'b1000_0000
	} state_t;

	cfg_t cfg;

	state_t state_q;
	logic [4:0] ri_q;
	logic [3:0] cj_q;
	logic       scan_vld_s1;
	logic [PRB_W-1:0] scan_i_s1;
	logic [SF_W-1:0]  scan_j_s1;
	logic       rd_vld_s1;
	logic [DEPTH-1:0] vld_q;
	logic       out_valid_q;
	out_item_t  out_item_q;

	// payload registers
	logic [CNT_W:0]     best_q;
	logic [PRB_W-1:0]   best_i_q;
	logic [SF_W-1:0]    best_j_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [9:0]         prod_q;
	logic [9:0]         pmi_q;
	logic [2:0]         status_q;
	logic [3:0]         rel_prb_q;
	logic [2:0]         rel_sf_q;
	logic               rel_in_q;

	logic in_accept;
	logic out_free;
	logic out_load;
	logic [4:0] rows_c;
	logic [3:0] cols_c;
	logic last_col;
	logic last_row;
	logic [ADDR_W-1:0] scan_addr;
	logic [ADDR_W-1:0] best_addr;
	logic [ADDR_W-1:0] rel_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic rd_en;
	logic wr_en;
	logic [CNT_W-1:0] wr_data;
	logic [CNT_W-1:0] ram_rdata;
	logic [CNT_W-1:0] rd_cnt;
	logic [CNT_W-1:0] mu_c;
	logic [7:0] off_c;
	logic [9:0] pmi_c;
	logic [2:0] status_c;
	logic [10:0] pucch_c;
	logic alloc_ok;
	logic rel_ok;

	cqips_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && ((state_q == S_COMMIT) || (state_q == S_REL_WR));
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// scan bounds, clamped to the table
	assign rows_c   = (cfg.prb_count > 5'(MAX_PRB)) ? 5'(MAX_PRB) : cfg.prb_count;
	assign cols_c   = (cfg.subframe_count > 4'(MAX_SF)) ? 4'(MAX_SF) : cfg.subframe_count;
	assign last_col = (cj_q == cols_c - 4'd1);
	assign last_row = (ri_q == rows_c - 5'd1);

	// table addresses: row * MAX_SF + column
	assign scan_addr = ADDR_W'(ri_q[PRB_W-1:0]) * ADDR_W'(MAX_SF) + ADDR_W'(cj_q[SF_W-1:0]);
	assign best_addr = ADDR_W'(best_i_q) * ADDR_W'(MAX_SF) + ADDR_W'(best_j_q);
	assign rel_addr  = ADDR_W'(rel_prb_q[PRB_W-1:0]) * ADDR_W'(MAX_SF) +
		ADDR_W'(rel_sf_q[SF_W-1:0]);

	// read port select
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_addr;
		unique case (state_q)
			S_SCAN: begin
				rd_en = 1'b1;
			end
			S_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = best_addr;
			end
			S_REL_RD: begin
				rd_en   = rel_in_q;
				rd_addr = rel_addr;
			end
			default: ;
		endcase
	end

	// an entry never written reads as zero
	assign rd_cnt = rd_vld_s1 ? ram_rdata : '0;

	// capacity, offset and PMI for the chosen slot
	assign mu_c  = users_per_prb(cfg.normal_cp, cfg.pucch_shift);
	assign off_c = cfg.subframe_offsets[{3'(best_j_q), 3'b000} +: 8];

	always_comb begin
		priority if (cfg.report_period == PER_32) begin
			pmi_c = PMI_BASE_32 + 10'(off_c);
		end else if (cfg.report_period == PER_64) begin
			pmi_c = PMI_BASE_64 + 10'(off_c);
		end else if (cfg.report_period == PER_128) begin
			pmi_c = PMI_BASE_128 + 10'(off_c);
		end else if (cfg.report_period > PER_2) begin
			pmi_c = 10'(cfg.report_period) - PMI_ADJ + 10'(off_c);
		end else begin
			pmi_c = 10'(off_c);
		end
	end

	always_comb begin
		priority if (rd_cnt > mu_c) begin
			status_c = ST_FULL;
		end else if (!period_valid(cfg.report_period)) begin
			status_c = ST_BAD_PERIOD;
		end else if (off_c >= cfg.report_period) begin
			status_c = ST_BAD_OFFSET;
		end else begin
			status_c = ST_OK;
		end
	end

	assign pucch_c  = 11'(prod_q) + 11'(cnt_q) + 11'(cfg.an_cyclic_shifts);
	assign alloc_ok = (status_q == ST_OK);
	assign rel_ok   = rel_in_q && (rd_cnt != '0);

	// write port: saturating increment on allocate, decrement on release
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_addr;
		wr_data = (cnt_q == '1) ? cnt_q : cnt_q + 6'd1;
		unique case (state_q)
			S_COMMIT: begin
				wr_en = out_free && alloc_ok;
			end
			S_REL_WR: begin
				wr_en   = out_free && rel_ok;
				wr_addr = rel_addr;
				wr_data = rd_cnt - 6'd1;
			end
			default: ;
		endcase
	end

	cqips_ram #(
		.WIDTH (CNT_W),
		.DEPTH (DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ri_q        <= '0;
			cj_q        <= '0;
			scan_vld_s1 <= 1'b0;
			rd_vld_s1   <= 1'b0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == S_SCAN);
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			// output register: load a finished result, else drop an accepted one
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					ri_q <= '0;
					cj_q <= '0;
					if (in_accept) begin
						if (in_item.action == ACT_RELEASE) begin
							state_q <= S_REL_RD;
						end else if ((rows_c == '0) || (cols_c == '0)) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (last_col) begin
						cj_q <= '0;
						ri_q <= ri_q + 5'd1;
						if (last_row) begin
							state_q <= S_DRAIN;
						end
					end else begin
						cj_q <= cj_q + 4'd1;
					end
				end
				S_DRAIN:  state_q <= S_FETCH;
				S_FETCH:  state_q <= S_CALC;
				S_CALC:   state_q <= S_COMMIT;
				S_REL_RD: state_q <= S_REL_WR;
				S_COMMIT, S_REL_WR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		scan_i_s1 <= ri_q[PRB_W-1:0];
		scan_j_s1 <= cj_q[SF_W-1:0];

		if (in_accept) begin
			best_q    <= 7'd64;
			best_i_q  <= '0;
			best_j_q  <= '0;
			rel_prb_q <= in_item.release_prb;
			rel_sf_q  <= in_item.release_sf;
			rel_in_q  <= (5'(in_item.release_prb) < 5'(MAX_PRB)) &&
				(4'(in_item.release_sf) < 4'(MAX_SF));
		end

		// shared compare: first slot with strictly fewer users wins
		if (scan_vld_s1 && ({1'b0, rd_cnt} < best_q)) begin
			best_q   <= {1'b0, rd_cnt};
			best_i_q <= scan_i_s1;
			best_j_q <= scan_j_s1;
		end

		if (state_q == S_CALC) begin
			cnt_q    <= rd_cnt;
			prod_q   <= 10'(best_i_q) * 10'(mu_c);
			pmi_q    <= pmi_c;
			status_q <= status_c;
		end

		if (out_free && (state_q == S_COMMIT)) begin
			out_item_q.status <= status_q;
			if (alloc_ok) begin
				out_item_q.pmi_index      <= pmi_q;
				out_item_q.pucch_index    <= pucch_c;
				out_item_q.prb_index      <= 4'(best_i_q);
				out_item_q.subframe_index <= 3'(best_j_q);
			end else begin
				out_item_q.pmi_index      <= '0;
				out_item_q.pucch_index    <= '0;
				out_item_q.prb_index      <= '0;
				out_item_q.subframe_index <= '0;
			end
		end else if (out_free && (state_q == S_REL_WR)) begin
			out_item_q.status         <= rel_ok ? ST_OK : ST_EMPTY;
			out_item_q.pmi_index      <= '0;
			out_item_q.pucch_index    <= '0;
			out_item_q.prb_index      <= rel_prb_q;
			out_item_q.subframe_index <= rel_sf_q;
		end
	end

endmodule

`default_nettype wire

[src/cqips_checker.sv]
// ---------------------------------------------------------------------------
// CQI PUCCH slot allocator port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cqi_pucch_slot_allocator_top_assert.svh"

module cqips_checker
	import cqips_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      pready,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_item
);

	// a stalled result transaction holds
	`CQIPS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

	// one request in flight: busy right after an accepted transaction
	`CQIPS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a second request while busy")

	// failed results carry zero PMI and PUCCH indexes
	`CQIPS_ASSERT_IMP(a_fail_zero, out_valid && (out_item.status != ST_OK), (out_item.pmi_index == '0) && (out_item.pucch_index == '0), "failed result with nonzero index")

	// status is a defined code
	`CQIPS_ASSERT_IMP(a_status_code, out_valid, out_item.status <= ST_EMPTY, "undefined status code")

	// register port has no wait states
	`CQIPS_ASSERT_IMP(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind cqi_pucch_slot_allocator_top cqips_checker u_cqips_checker (.*);

`default_nettype wire

[verif/cqi_pucch_slot_allocator_top_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CQI PUCCH slot allocator testbench
// Drives allocate and release transactions through the valid/stall input
// channel and checks every result against an in-bench model of the slot
// table, under a series of register settings written over the APB port
// between phases. Both channels idle in random bursts; one long sink
// hold-off backs the block up into its input.
// ---------------------------------------------------------------------------

module cqi_pucch_slot_allocator_top_test;
	import cqips_pkg::*;

	localparam int unsigned TBL_ROWS   = MAX_PRB_DEF;
	localparam int unsigned TBL_COLS   = MAX_SF_DEF;
	localparam int unsigned ITEM_GOAL  = 1700;
	localparam int unsigned QUIET_FROM = 1450;
	localparam int unsigned HOLD_LEN   = 400;
	localparam int unsigned DRAIN_WAIT = 150;
	localparam int unsigned LIMIT      = 1500000;

	// clock, reset and DUT ports
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	in_item_t           in_item   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_item;

	// model state and transaction stores
	logic [CNT_W-1:0] slot_users [0:TBL_ROWS*TBL_COLS-1];
	cfg_t             cur_cfg;
	in_item_t         pending_q [$];
	out_item_t        expected_q [$];

	int unsigned fail_cnt    = 0;
	int unsigned cycle_cnt   = 0;
	int unsigned src_gap     = 0;
	int unsigned sink_gap    = 0;
	int unsigned hold_cycles = 0;
	bit          idle_on     = 1'b1;
	bit          hold_go     = 1'b0;
	logic        long_hold   = 1'b0;

	cqi_pucch_slot_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	// model of one request: slot scan, checks, table update
	task automatic predict_result(input in_item_t req, output out_item_t res);
		int unsigned rows, cols, shift, mu, best, bi, bj, cnt, off, pmi, k, i, j;
		logic        period_ok;
		res = '0;
		if (req.action == ACT_RELEASE) begin
			res.status         = ST_EMPTY;
			res.prb_index      = req.release_prb;
			res.subframe_index = req.release_sf;
			if (req.release_prb < TBL_ROWS && req.release_sf < TBL_COLS) begin
				k = req.release_prb * TBL_COLS + req.release_sf;
				if (slot_users[k] != 0) begin
					slot_users[k] = slot_users[k] - 1'b1;
					res.status = ST_OK;
				end
			end
		end else begin
			rows  = (cur_cfg.prb_count > TBL_ROWS) ? TBL_ROWS : cur_cfg.prb_count;
			cols  = (cur_cfg.subframe_count > TBL_COLS) ? TBL_COLS : cur_cfg.subframe_count;
			shift = (cur_cfg.pucch_shift == 0) ? 1 : cur_cfg.pucch_shift;
			mu    = 12 * (cur_cfg.normal_cp ? 3 : 2) / shift;
			best  = 64;
			bi    = 0;
			bj    = 0;
			// first slot with the fewest users, row-major
			for (i = 0; i < rows; i++) begin
				for (j = 0; j < cols; j++) begin
					if (slot_users[i*TBL_COLS + j] < best) begin
						best = slot_users[i*TBL_COLS + j];
						bi   = i;
						bj   = j;
					end
				end
			end
			k   = bi * TBL_COLS + bj;
			cnt = slot_users[k];
			case (cur_cfg.report_period)
				PER_2, 8'd5, 8'd10, 8'd20, 8'd40, 8'd80, 8'd160, PER_32, PER_64, PER_128:
					period_ok = 1'b1;
				default: period_ok = 1'b0;
			endcase
			off = cur_cfg.subframe_offsets[8*bj +: 8];
			if (cnt > mu) begin
				res.status = ST_FULL;
			end else if (!period_ok) begin
				res.status = ST_BAD_PERIOD;
			end else if (off >= cur_cfg.report_period) begin
				res.status = ST_BAD_OFFSET;
			end else begin
				if (cur_cfg.report_period == PER_32) pmi = PMI_BASE_32 + off;
				else if (cur_cfg.report_period == PER_64) pmi = PMI_BASE_64 + off;
				else if (cur_cfg.report_period == PER_128) pmi = PMI_BASE_128 + off;
				else if (cur_cfg.report_period > PER_2) pmi = cur_cfg.report_period - PMI_ADJ + off;
				else pmi = off;
				res.status         = ST_OK;
				res.pmi_index      = 10'(pmi);
				res.pucch_index    = 11'(bi * mu + cnt + cur_cfg.an_cyclic_shifts);
				res.prb_index      = 4'(bi);
				res.subframe_index = 3'(bj);
				if (slot_users[k] < 63) slot_users[k] = slot_users[k] + 1'b1;
			end
		end
	endtask

	// input driver: feeds pending transactions, random gaps after acceptance
	always @(posedge clk) begin : drive_requests
		out_item_t res;
		logic      fire;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			fire = in_valid && !in_stall;
			if (fire) begin
				predict_result(in_item, res);
				expected_q.insert(expected_q.size(), res);
			end
			if (in_valid && !fire) begin
				// stalled: payload holds
			end else if (src_gap != 0) begin
				src_gap  <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (fire && idle_on && $urandom_range(0, 4) == 0) begin
				src_gap  <= $urandom_range(0, 9);
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				in_valid <= 1'b1;
				in_item  <= pending_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long sink hold-off, once armed
	always @(posedge clk) begin : hold_sink
		if (!arst_n) begin
			long_hold <= 1'b0;
		end else if (hold_go && hold_cycles < HOLD_LEN) begin
			long_hold   <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			long_hold <= 1'b0;
		end
	end

	// result monitor and sink stall
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected result: st=%0d pmi=%0d pucch=%0d prb=%0d sf=%0d",
							out_item.status, out_item.pmi_index, out_item.pucch_index,
							out_item.prb_index, out_item.subframe_index);
				end else begin
					want = expected_q.pop_front();
					if (out_item.status !== want.status ||
						out_item.pmi_index !== want.pmi_index ||
						out_item.pucch_index !== want.pucch_index ||
						out_item.prb_index !== want.prb_index ||
						out_item.subframe_index !== want.subframe_index) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("mismatch @%0d: exp st=%0d pmi=%0d pucch=%0d prb=%0d sf=%0d, got st=%0d pmi=%0d pucch=%0d prb=%0d sf=%0d",
								cycle_cnt, want.status, want.pmi_index, want.pucch_index,
								want.prb_index, want.subframe_index,
								out_item.status, out_item.pmi_index, out_item.pucch_index,
								out_item.prb_index, out_item.subframe_index);
					end
				end
			end
			if (long_hold) begin
				out_stall <= 1'b1;
			end else if (sink_gap != 0) begin
				sink_gap  <= sink_gap - 1;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				sink_gap  <= $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// one register write: setup then access cycle
	task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx) << 3;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PRB_COUNT:   cur_cfg.prb_count        = val[4:0];
			REG_SF_COUNT:    cur_cfg.subframe_count   = val[3:0];
			REG_NORMAL_CP:   cur_cfg.normal_cp        = val[0];
			REG_PUCCH_SHIFT: cur_cfg.pucch_shift      = val[1:0];
			REG_AN_CS:       cur_cfg.an_cyclic_shifts = val[2:0];
			REG_PERIOD:      cur_cfg.report_period    = val[7:0];
			REG_SF_OFFSETS:  cur_cfg.subframe_offsets = val;
			default: ;
		endcase
	endtask

	task automatic write_config(input cfg_t c);
		apb_write(REG_PRB_COUNT,   64'(c.prb_count));
		apb_write(REG_SF_COUNT,    64'(c.subframe_count));
		apb_write(REG_NORMAL_CP,   64'(c.normal_cp));
		apb_write(REG_PUCCH_SHIFT, 64'(c.pucch_shift));
		apb_write(REG_AN_CS,       64'(c.an_cyclic_shifts));
		apb_write(REG_PERIOD,      64'(c.report_period));
		apb_write(REG_SF_OFFSETS,  c.subframe_offsets);
	endtask

	function automatic logic [7:0] period_pick(input int unsigned n);
		case (n)
			0: return PER_2;
			1: return 8'd5;
			2: return 8'd10;
			3: return 8'd20;
			4: return 8'd40;
			5: return 8'd80;
			6: return 8'd160;
			7: return PER_32;
			8: return PER_64;
			default: return PER_128;
		endcase
	endfunction

	// random setting, small tables most of the time
	task automatic pick_config(input bit full_size, output cfg_t c);
		int unsigned j;
		c = '0;
		case ($urandom_range(0, 9))
			0: c.prb_count = 5'd0;
			1: c.prb_count = 5'($urandom_range(17, 31));
			2: c.prb_count = 5'd16;
			default: c.prb_count = 5'($urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 9))
			0: c.subframe_count = 4'd0;
			1: c.subframe_count = 4'($urandom_range(9, 15));
			2: c.subframe_count = 4'd8;
			default: c.subframe_count = 4'($urandom_range(1, 4));
		endcase
		if (full_size) begin
			c.prb_count      = 5'd16;
			c.subframe_count = 4'd8;
		end
		c.normal_cp        = 1'($urandom);
		c.pucch_shift      = 2'($urandom);
		c.an_cyclic_shifts = 3'($urandom);
		if ($urandom_range(0, 6) == 0) c.report_period = 8'($urandom);
		else c.report_period = period_pick($urandom_range(0, 9));
		for (j = 0; j < 8; j++) begin
			if ($urandom_range(0, 4) != 0 && c.report_period != 0)
				c.subframe_offsets[8*j +: 8] = 8'($urandom_range(0, c.report_period - 1));
			else
				c.subframe_offsets[8*j +: 8] = 8'($urandom);
		end
	endtask

	// mostly allocations and releases inside the active table, some noise
	task automatic load_requests(input int unsigned n, input int unsigned alloc_pct);
		int unsigned rows, cols, roll, k;
		in_item_t    req;
		rows = (cur_cfg.prb_count == 0) ? 1 :
			((cur_cfg.prb_count > TBL_ROWS) ? TBL_ROWS : cur_cfg.prb_count);
		cols = (cur_cfg.subframe_count == 0) ? 1 :
			((cur_cfg.subframe_count > TBL_COLS) ? TBL_COLS : cur_cfg.subframe_count);
		for (k = 0; k < n; k++) begin
			req  = in_item_t'(8'($urandom));
			roll = $urandom_range(0, 99);
			if (roll < alloc_pct) begin
				req.action = ACT_ALLOC;
			end else begin
				req.action = ACT_RELEASE;
				if (roll < 93) begin
					req.release_prb = 4'($urandom_range(0, rows - 1));
					req.release_sf  = 3'($urandom_range(0, cols - 1));
				end
			end
			pending_q.insert(pending_q.size(), req);
		end
	endtask

	task automatic push_req(input logic act, input logic [3:0] prb, input logic [2:0] sf);
		in_item_t req;
		req.action      = act;
		req.release_prb = prb;
		req.release_sf  = sf;
		pending_q.insert(pending_q.size(), req);
	endtask

	// block idle: nothing pending, nothing offered, nothing outstanding
	task automatic wait_idle();
		@(negedge clk);
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
	endtask

	initial begin : watchdog
		while (cycle_cnt < LIMIT) @(posedge clk);
		$display("FAIL cqi_pucch_slot_allocator_top");
		$finish;
	end

	initial begin : main_seq
		cfg_t        c;
		int unsigned k, n, item_total, phase_no;

		for (k = 0; k < TBL_ROWS*TBL_COLS; k++) slot_users[k] = '0;
		cur_cfg.prb_count        = 5'd1;
		cur_cfg.subframe_count   = 4'd1;
		cur_cfg.normal_cp        = 1'b1;
		cur_cfg.pucch_shift      = 2'd1;
		cur_cfg.an_cyclic_shifts = 3'd0;
		cur_cfg.report_period    = 8'd40;
		cur_cfg.subframe_offsets = 64'd0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: allocate, release down to empty, release far corner
		@(negedge clk);
		push_req(ACT_ALLOC, 4'd0, 3'd0);
		push_req(ACT_ALLOC, 4'd15, 3'd7);
		push_req(ACT_RELEASE, 4'd0, 3'd0);
		push_req(ACT_RELEASE, 4'd0, 3'd0);
		push_req(ACT_RELEASE, 4'd0, 3'd0);
		push_req(ACT_RELEASE, 4'd15, 3'd7);
		wait_idle();

		// zero rows and columns, extended CP, shift 3: fill slot (0,0) past capacity
		c = '0;
		c.pucch_shift      = 2'd3;
		c.an_cyclic_shifts = 3'd7;
		c.report_period    = PER_128;
		c.subframe_offsets = 64'h0000_0000_0000_007F;
		write_config(c);
		@(negedge clk);
		for (k = 0; k < 10; k++) push_req(ACT_ALLOC, 4'd0, 3'd0);
		wait_idle();

		// counts above range, shift 0, invalid period
		c.prb_count        = 5'd31;
		c.subframe_count   = 4'd15;
		c.normal_cp        = 1'b1;
		c.pucch_shift      = 2'd0;
		c.an_cyclic_shifts = 3'd0;
		c.report_period    = 8'd255;
		c.subframe_offsets = 64'd0;
		write_config(c);
		@(negedge clk);
		push_req(ACT_ALLOC, 4'd0, 3'd0);
		wait_idle();

		// largest period with largest legal offset
		c.report_period    = 8'd160;
		c.subframe_offsets = {8{8'h9F}};
		write_config(c);
		@(negedge clk);
		push_req(ACT_ALLOC, 4'd0, 3'd0);
		wait_idle();

		// period 2
		c.report_period    = PER_2;
		c.subframe_offsets = {8{8'h01}};
		write_config(c);
		@(negedge clk);
		push_req(ACT_ALLOC, 4'd0, 3'd0);
		wait_idle();

		// offset equal to the period
		c.report_period    = PER_64;
		c.subframe_offsets = {8{8'h40}};
		write_config(c);
		@(negedge clk);
		push_req(ACT_ALLOC, 4'd0, 3'd0);
		wait_idle();

		// period 32, top offset
		c.report_period    = PER_32;
		c.subframe_offsets = {8{8'h1F}};
		write_config(c);
		@(negedge clk);
		push_req(ACT_ALLOC, 4'd0, 3'd0);
		wait_idle();

		// random phases, each under a fresh setting
		item_total = 21;
		phase_no   = 0;
		while (item_total < ITEM_GOAL) begin
			pick_config(phase_no == 3 || phase_no == 9, c);
			write_config(c);
			n = $urandom_range(60, 110);
			@(negedge clk);
			if (phase_no == 0) hold_go = 1'b1;
			if (item_total > QUIET_FROM) idle_on = 1'b0;
			load_requests(n, $urandom_range(45, 85));
			item_total += n;
			wait_idle();
			phase_no++;
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_q.size() != 0) fail_cnt++;
		if (fail_cnt == 0) begin
			$display("PASS cqi_pucch_slot_allocator_top");
		end else begin
			$display("FAIL cqi_pucch_slot_allocator_top");
		end
		$finish;
	end

endmodule
